@@ hdl/nll_pkg.sv @@
// Shared types, register indexes and helpers of the note length limiter.
// No dependencies; the front, back, top and test files import this package.
package nll_pkg;

	localparam int unsigned MAX_FRAME   = 8192;
	localparam int unsigned FULL_Q16    = 65536;
	localparam int unsigned TRIGGER_MIN = 65;

	// register indexes of the configuration port
	localparam logic [2:0] REG_FRAME     = 3'd0;
	localparam logic [2:0] REG_LIMIT     = 3'd1;
	localparam logic [2:0] REG_CLIP_LOW  = 3'd2;
	localparam logic [2:0] REG_CLIP_HIGH = 3'd3;
	localparam logic [2:0] REG_GAIN      = 3'd4;

	// event kinds
	localparam logic EV_ON  = 1'b0;
	localparam logic EV_OFF = 1'b1;

	localparam logic [6:0] VEL_OFF = 7'd127;

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_TRIGGER = 2'd1,
		ACT_END     = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_EXEC,
		B_ON
	} back_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [6:0]  note;
		logic [15:0] sample_position;
		logic [17:0] strength;
	} nll_in_t;

	typedef struct packed {
		logic        event_kind;
		logic [6:0]  event_note;
		logic [6:0]  velocity;
		logic [12:0] event_offset;
		logic        last;
	} nll_out_t;

	// effective configuration, already limited to its meaningful range
	typedef struct packed {
		logic [13:0] frame;
		logic [23:0] limit;
		logic [16:0] clip_low;
		logic [16:0] clip_high;
		logic [16:0] gain;
	} nll_cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		act_t        action;
		logic [6:0]  note;
		logic [12:0] pos;
		logic [6:0]  vel;
	} nll_job_t;

	function automatic logic [13:0] frame_eff(input logic [13:0] f);
		logic [13:0] r;
		if (f == 14'd0) begin
			r = 14'd1;
		end else if (f > 14'(MAX_FRAME)) begin
			r = 14'(MAX_FRAME);
		end else begin
			r = f;
		end
		return r;
	endfunction

	function automatic logic [16:0] sat_q16(input logic [16:0] v);
		return (v > 17'(FULL_Q16)) ? 17'(FULL_Q16) : v;
	endfunction

endpackage

@@ hdl/nll_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/nll_fifo.sv @@
// Small first-in first-out queue in flip-flops, used between the stages
// and at the result side. No dependencies.
module nll_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

@@ hdl/nll_front.sv @@
// Front stage: accepts items, drops those that cause nothing, reduces the
// position modulo the frame bit by bit and works out the note-on velocity.
// Depends on nll_pkg.
module nll_front import nll_pkg::*; #(
	parameter int NOTE_COUNT = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  nll_in_t  item,
	input  logic     push,
	output logic     full,
	input  nll_cfg_t cfg,
	output nll_job_t job,
	output logic     job_push,
	input  logic     job_full
);

	localparam logic [7:0] NOTE_LIM = 8'(NOTE_COUNT);

	front_state_t state_q;
	front_state_t state_d;

	act_t        action_q;
	logic [6:0]  note_q;
	logic [15:0] dvd_q;
	logic [17:0] strength_q;
	logic [12:0] rem_q;
	logic [3:0]  cnt_q;

	logic        accept;
	logic        keep;
	logic        need_div;
	logic [13:0] trial;
	logic [13:0] trial_red;

	// velocity pipeline
	logic [16:0] s_sat;
	logic [16:0] range;
	logic [33:0] prod;
	logic [32:0] v_s1;
	logic [49:0] vg_s2;
	logic [56:0] p127;
	logic [56:0] rnd;
	logic [6:0]  vel_s3;

	assign accept = push && (state_q == F_IDLE);

	always_comb begin
		keep     = 1'b0;
		need_div = 1'b0;
		case (item.action)
			ACT_START, ACT_END: begin
				keep = ({1'b0, item.note} < NOTE_LIM);
			end
			ACT_TRIGGER: begin
				keep     = ({1'b0, item.note} < NOTE_LIM) &&
				           (item.strength > 18'(TRIGGER_MIN));
				need_div = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		full     = 1'b1;
		job_push = 1'b0;
		case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push && keep) begin
					state_d = need_div ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (cnt_q == 4'd0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				job_push = !job_full;
				if (!job_full) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// restoring remainder step: one dividend bit per cycle
	assign trial     = {rem_q, dvd_q[15]};
	assign trial_red = (trial >= cfg.frame) ? trial - cfg.frame : trial;

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= act_t'(item.action);
			note_q     <= item.note;
			dvd_q      <= item.sample_position;
			strength_q <= item.strength;
			rem_q      <= '0;
			cnt_q      <= 4'd15;
		end else if (state_q == F_DIV) begin
			rem_q <= trial_red[12:0];
			dvd_q <= {dvd_q[14:0], 1'b0};
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// velocity = round(127 * (lo + range * min(s, 1)) * gain), Q1.32 * Q1.16
	assign s_sat = (strength_q > 18'(FULL_Q16)) ? 17'(FULL_Q16) : strength_q[16:0];
	assign range = (cfg.clip_high > cfg.clip_low) ? cfg.clip_high - cfg.clip_low : '0;
	assign prod  = range * s_sat;
	assign p127  = {vg_s2, 7'd0} - {7'd0, vg_s2};
	assign rnd   = p127 + (57'd1 << 47);

	always_ff @(posedge clk) begin
		v_s1   <= prod[32:0] + {cfg.clip_low, 16'd0};
		vg_s2  <= v_s1 * cfg.gain;
		vel_s3 <= (rnd[56:48] > 9'd127) ? 7'd127 : rnd[54:48];
	end

	assign job = '{action: action_q, note: note_q, pos: rem_q, vel: vel_s3};

endmodule

@@ hdl/nll_back.sv @@
// Back stage: read-modify-write of the per-note age counters and emission
// of note-off and note-on events. Depends on nll_pkg and nll_ram.
module nll_back import nll_pkg::*; #(
	parameter int NOTE_COUNT = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  nll_cfg_t cfg,
	input  nll_job_t job,
	input  logic     job_empty,
	output logic     job_pop,
	output nll_out_t result,
	output logic     res_push,
	input  logic     res_full
);

	localparam int AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

	back_state_t state_q;
	back_state_t state_d;

	nll_job_t              job_q;
	logic [31:0]           age_q;
	logic [NOTE_COUNT-1:0] valid_q;

	logic [AW-1:0] idx;
	logic          we;
	logic [31:0]   wdata;
	logic [31:0]   rdata;
	logic          clr_v;
	logic          emit;

	logic          over;
	logic [33:0]   e;
	logic [12:0]   auto_end;
	logic [12:0]   off_pos;
	logic [32:0]   aged;

	assign idx = job_q.note[AW-1:0];

	nll_ram #(
		.WIDTH (32),
		.DEPTH (NOTE_COUNT)
	) u_age (
		.clk   (clk),
		.we    (we),
		.waddr (idx),
		.wdata (wdata),
		.raddr (job.note[AW-1:0]),
		.rdata (rdata)
	);

	// automatic end: frame - 1 - (age - limit), saturated at zero
	assign over     = (cfg.limit != 24'd0) && (age_q > {8'd0, cfg.limit});
	assign e        = 34'(cfg.frame) - 34'd1 + 34'(cfg.limit) - 34'(age_q);
	assign auto_end = e[33] ? 13'd0 : e[12:0];
	assign off_pos  = (over && (auto_end < job_q.pos)) ? auto_end : job_q.pos;
	assign aged     = 33'(age_q) + 33'(cfg.frame);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (we) begin
				valid_q[idx] <= 1'b1;
			end else if (clr_v) begin
				valid_q[idx] <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		we      = 1'b0;
		wdata   = '0;
		clr_v   = 1'b0;
		emit    = 1'b0;
		result  = '{event_kind: EV_OFF, event_note: job_q.note, velocity: VEL_OFF,
		            event_offset: off_pos, last: 1'b0};
		case (state_q)
			B_IDLE: begin
				job_pop = !job_empty;
				if (!job_empty) begin
					state_d = B_READ;
				end
			end
			B_READ: begin
				state_d = B_EXEC;
			end
			B_EXEC: begin
				case (job_q.action)
					ACT_START: begin
						// age a playing note, saturating
						we      = (age_q != 32'd0);
						wdata   = aged[32] ? 32'hFFFF_FFFF : aged[31:0];
						state_d = B_IDLE;
					end
					ACT_END: begin
						if (over) begin
							emit                = 1'b1;
							result.event_offset = auto_end;
							result.last         = 1'b1;
							if (!res_full) begin
								clr_v   = 1'b1;
								state_d = B_IDLE;
							end
						end else begin
							state_d = B_IDLE;
						end
					end
					ACT_TRIGGER: begin
						if (age_q != 32'd0) begin
							emit = 1'b1;
							if (!res_full) begin
								state_d = B_ON;
							end
						end else begin
							state_d = B_ON;
						end
					end
					default: begin
						state_d = B_IDLE;
					end
				endcase
			end
			B_ON: begin
				emit   = 1'b1;
				result = '{event_kind: EV_ON, event_note: job_q.note, velocity: job_q.vel,
				           event_offset: job_q.pos, last: 1'b1};
				if (!res_full) begin
					we      = 1'b1;
					wdata   = 32'(cfg.frame - 14'd1 - {1'b0, job_q.pos});
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	assign res_push = emit && !res_full;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == B_READ) begin
			age_q <= valid_q[idx] ? rdata : 32'd0;
		end
	end

endmodule

@@ hdl/note_length_limiter.sv @@
// Note length limiter: per-note age counters and MIDI note event generation.
//
// Input side is a queue: present an item and raise push; it is taken at an
// edge where full is low. Result side is a queue too: while empty is low the
// oldest event sits on result and is taken at an edge where pop is high.
// Configuration is a plain write port (wr_en, wr_index, wr_data); the user must
// use it only while the block is idle, unenforced; registers take effect at once.
//
// Flow: an activation holds the input through acceptance, the sixteen steps
// of the bit-serial position modulo and the hand-off; block start and block
// end items hold it through acceptance and hand-off, dropped items only while
// they are accepted. The back stage takes each item through an age memory read,
// an update and one or two events, so the modulo unit sets the throughput.
// With the back stage free, an activation's first event enters the result
// queue in the update step, or in the note-on step when no note-off comes first.
// Reset clears all ages through per-note valid bits, so no clearing pass is
// needed. When the receiver stalls, results build up in a two-beat queue,
// then in the queue between the stages, and then full rises.
module note_length_limiter import nll_pkg::*; #(
	parameter int NOTE_COUNT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  nll_in_t     item,
	input  logic        push,
	output logic        full,
	output nll_out_t    result,
	output logic        empty,
	input  logic        pop,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [23:0] wr_data
);

	localparam logic [7:0] NOTE_LIM = 8'(NOTE_COUNT);

	logic [13:0] frame_q;
	logic [23:0] limit_q;
	logic [16:0] clip_low_q;
	logic [16:0] clip_high_q;
	logic [16:0] gain_q;
	nll_cfg_t    cfg;

	nll_job_t job_in;
	nll_job_t job_head;
	logic     job_push;
	logic     job_full;
	logic     job_pop;
	logic     job_empty;

	nll_out_t res_in;
	logic     res_push;
	logic     res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= 14'd512;
			limit_q     <= 24'd0;
			clip_low_q  <= 17'd0;
			clip_high_q <= 17'(FULL_Q16);
			gain_q      <= 17'(FULL_Q16);
		end else if (wr_en) begin
			case (wr_index)
				REG_FRAME:     frame_q     <= wr_data[13:0];
				REG_LIMIT:     limit_q     <= wr_data;
				REG_CLIP_LOW:  clip_low_q  <= wr_data[16:0];
				REG_CLIP_HIGH: clip_high_q <= wr_data[16:0];
				REG_GAIN:      gain_q      <= wr_data[16:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = '{frame:     frame_eff(frame_q),
	               limit:     limit_q,
	               clip_low:  sat_q16(clip_low_q),
	               clip_high: sat_q16(clip_high_q),
	               gain:      sat_q16(gain_q)};

	nll_front #(
		.NOTE_COUNT (NOTE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.cfg      (cfg),
		.job      (job_in),
		.job_push (job_push),
		.job_full (job_full)
	);

	nll_fifo #(
		.WIDTH ($bits(nll_job_t)),
		.DEPTH (2)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.rd     (job_pop),
		.rdata  (job_head),
		.empty  (job_empty)
	);

	nll_back #(
		.NOTE_COUNT (NOTE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (job_head),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.result    (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	nll_fifo #(
		.WIDTH ($bits(nll_out_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

	// a note-off always carries full velocity
	a_off_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.event_kind == EV_OFF) |-> result.velocity == VEL_OFF)
		else $error("note-off beat without full velocity");

	// a note-on is always the final event of its item
	a_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.event_kind == EV_ON) |-> result.last)
		else $error("note-on beat not marked last");

	// only notes within the table reach the output
	a_note_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, result.event_note} < NOTE_LIM))
		else $error("event for a note outside the table");

	// nothing is waiting right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

endmodule

@@ test/nll_checker.sv @@
`timescale 1ns / 100ps
// Event checker of the note length limiter: watches the item, event and register
// channels, predicts every note event and compares each event beat in order.
// Depends on nll_pkg for the payload structs, event codes and register indexes.
module nll_checker import nll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  nll_in_t     item,
	input  logic        push,
	input  logic        full,
	input  nll_out_t    result,
	input  logic        empty,
	input  logic        pop,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [23:0] wr_data,
	output int          errors,
	output int          pending
);

	localparam int NOTES = 128;

	logic [31:0] age_of [NOTES];
	logic [13:0] frame_cfg;
	logic [23:0] limit_cfg;
	logic [16:0] low_cfg;
	logic [16:0] high_cfg;
	logic [16:0] gain_cfg;
	nll_out_t    events_due [$];
	int          fault_count = 0;
	int          events_seen = 0;

	assign errors = fault_count;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fault_count++;
	endtask

	function automatic logic [63:0] unit_clamp(input logic [16:0] v);
		return (v > 17'(FULL_Q16)) ? 64'(FULL_Q16) : 64'(v);
	endfunction

	function automatic bit past_limit(input logic [31:0] age);
		return limit_cfg != 24'd0 && age > {8'd0, limit_cfg};
	endfunction

	// sample where the limit ran out, held at sample 0 when that lies before the buffer
	function automatic logic [12:0] limit_end(input logic [31:0] age, input logic [13:0] fs);
		longint a;
		longint f;
		longint l;
		longint e;
		a = age;
		f = fs;
		l = limit_cfg;
		e = f - 1 - (a - l);
		return (e < 0) ? 13'd0 : 13'(e);
	endfunction

	function automatic nll_out_t note_event(input logic kind, input logic [6:0] note,
			input logic [6:0] vel, input logic [12:0] offset, input logic last);
		nll_out_t ev;
		ev.event_kind   = kind;
		ev.event_note   = note;
		ev.velocity     = vel;
		ev.event_offset = offset;
		ev.last         = last;
		return ev;
	endfunction

	task automatic predict_events(input nll_in_t it);
		logic [13:0] fs;
		logic [31:0] age;
		logic [12:0] pos;
		logic [12:0] stop;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] span;
		logic [63:0] s;
		logic [63:0] level;
		logic [63:0] scaled;
		logic [6:0]  vel;
		fs = frame_cfg;
		if (fs == 14'd0) begin
			fs = 14'd1;
		end else if (fs > 14'(MAX_FRAME)) begin
			fs = 14'(MAX_FRAME);
		end
		age = age_of[it.note];
		case (it.action)
			ACT_START: begin
				if (age != 32'd0) begin
					age_of[it.note] = (age > 32'hFFFF_FFFF - 32'(fs)) ? 32'hFFFF_FFFF
						: age + 32'(fs);
				end
			end
			ACT_TRIGGER: begin
				pos = 13'(it.sample_position % 16'(fs));
				if (it.strength > 18'(TRIGGER_MIN)) begin
					if (age != 32'd0) begin
						stop = pos;
						if (past_limit(age) && limit_end(age, fs) < stop) begin
							stop = limit_end(age, fs);
						end
						events_due.push_back(note_event(EV_OFF, it.note, VEL_OFF, stop, 1'b0));
					end
					// level in Q1.32, times gain Q1.16 and 127, rounded half up
					lo = unit_clamp(low_cfg);
					hi = unit_clamp(high_cfg);
					span = (hi > lo) ? hi - lo : 64'd0;
					s = (it.strength > 18'(FULL_Q16)) ? 64'(FULL_Q16) : 64'(it.strength);
					level = (lo << 16) + span * s;
					scaled = (level * unit_clamp(gain_cfg) * 64'd127 + (64'd1 << 47)) >> 48;
					vel = (scaled > 64'd127) ? 7'd127 : scaled[6:0];
					events_due.push_back(note_event(EV_ON, it.note, vel, pos, 1'b1));
					age_of[it.note] = 32'(fs) - 32'd1 - 32'(pos);
				end
			end
			ACT_END: begin
				if (past_limit(age)) begin
					events_due.push_back(note_event(EV_OFF, it.note, VEL_OFF,
						limit_end(age, fs), 1'b1));
					age_of[it.note] = 32'd0;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		nll_out_t want;
		if (!arst_n) begin
			foreach (age_of[i]) begin
				age_of[i] = 32'd0;
			end
			frame_cfg = 14'd512;
			limit_cfg = 24'd0;
			low_cfg   = 17'd0;
			high_cfg  = 17'(FULL_Q16);
			gain_cfg  = 17'(FULL_Q16);
			events_due.delete();
			pending <= 0;
		end else begin
			// retire the event beat before predicting from a new item beat
			if (pop && !empty) begin
				if (events_due.size() == 0) begin
					report_mismatch($sformatf("event %0d (note %0d) with nothing due",
						events_seen, result.event_note));
				end else begin
					want = events_due.pop_front();
					if (result.event_kind !== want.event_kind)
						report_mismatch($sformatf("event %0d kind: got %0d, want %0d",
							events_seen, result.event_kind, want.event_kind));
					if (result.event_note !== want.event_note)
						report_mismatch($sformatf("event %0d note: got %0d, want %0d",
							events_seen, result.event_note, want.event_note));
					if (result.velocity !== want.velocity)
						report_mismatch($sformatf("event %0d velocity: got %0d, want %0d",
							events_seen, result.velocity, want.velocity));
					if (result.event_offset !== want.event_offset)
						report_mismatch($sformatf("event %0d offset: got %0d, want %0d",
							events_seen, result.event_offset, want.event_offset));
					if (result.last !== want.last)
						report_mismatch($sformatf("event %0d last: got %0d, want %0d",
							events_seen, result.last, want.last));
				end
				events_seen++;
			end
			if (push && !full) begin
				predict_events(item);
			end
			if (wr_en) begin
				case (wr_index)
					REG_FRAME:     frame_cfg = wr_data[13:0];
					REG_LIMIT:     limit_cfg = wr_data;
					REG_CLIP_LOW:  low_cfg   = wr_data[16:0];
					REG_CLIP_HIGH: high_cfg  = wr_data[16:0];
					REG_GAIN:      gain_cfg  = wr_data[16:0];
					default: begin
					end
				endcase
			end
			pending <= events_due.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top of the note length limiter: clock, reset, register phases and
// item stimulus. Needs nll_pkg, note_length_limiter and nll_checker.
module tb_top;
	import nll_pkg::*;

	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         SETTLE       = 100;
	localparam int         RANDOM_ITEMS = 1550;
	localparam int         PHASES       = 9;
	localparam logic [1:0] ACT_SPARE    = 2'd3;

	logic        clk;
	logic        arst_n = 1'b0;
	nll_in_t     item = '0;
	logic        push = 1'b0;
	logic        full;
	nll_out_t    result;
	logic        empty;
	logic        pop = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = REG_FRAME;
	logic [23:0] wr_data = '0;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          frame_now = 512;
	logic [6:0]  pool [4];

	note_length_limiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.result   (result),
		.empty    (empty),
		.pop      (pop),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	nll_checker event_watch (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.result   (result),
		.empty    (empty),
		.pop      (pop),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic nll_in_t make_item(input logic [1:0] action, input logic [6:0] note,
			input logic [15:0] pos, input logic [17:0] strength);
		nll_in_t it;
		it.action          = action;
		it.note            = note;
		it.sample_position = pos;
		it.strength        = strength;
		return it;
	endfunction

	task automatic refresh_pool();
		foreach (pool[i]) begin
			pool[i] = 7'($urandom_range(127));
		end
	endtask

	task automatic send_item(input nll_in_t it);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	// hold the sender until every due event is out and the pipe has run dry
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs(input logic [23:0] frame, input logic [23:0] limit,
			input logic [23:0] lo, input logic [23:0] hi, input logic [23:0] gain);
		logic [2:0]  idx [5];
		logic [23:0] val [5];
		idx = '{REG_FRAME, REG_LIMIT, REG_CLIP_LOW, REG_CLIP_HIGH, REG_GAIN};
		val = '{frame, limit, lo, hi, gain};
		for (int i = 0; i < 5; i++) begin
			wr_en    <= 1'b1;
			wr_index <= idx[i];
			wr_data  <= val[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		if (frame[13:0] == 14'd0) begin
			frame_now = 1;
		end else if (frame[13:0] > 14'(MAX_FRAME)) begin
			frame_now = MAX_FRAME;
		end else begin
			frame_now = frame[13:0];
		end
	endtask

	initial begin
		int          done;
		nll_in_t     noise;
		logic [15:0] pos;
		logic [17:0] strength;
		refresh_pool();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(24'd512, 24'd600, 24'd0, 24'(FULL_Q16), 24'(FULL_Q16));
		// trigger threshold: 65 stays silent, 66 fires
		send_item(make_item(ACT_TRIGGER, 7'd0, 16'd0, 18'd65));
		send_item(make_item(ACT_TRIGGER, 7'd0, 16'd0, 18'd66));
		// position wraps onto the last sample, leaving the note counted as silent
		send_item(make_item(ACT_TRIGGER, 7'd0, 16'hFFFF, 18'h3FFFF));
		send_item(make_item(ACT_START, 7'd0, 16'd0, 18'd0));
		send_item(make_item(ACT_END, 7'd0, 16'd0, 18'd0));
		// over the limit at block end
		send_item(make_item(ACT_TRIGGER, 7'd127, 16'd100, 18'(FULL_Q16)));
		send_item(make_item(ACT_START, 7'd127, 16'd0, 18'd0));
		send_item(make_item(ACT_END, 7'd127, 16'd0, 18'd0));
		// far over the limit: the automatic end falls before the buffer
		send_item(make_item(ACT_TRIGGER, 7'd5, 16'd0, 18'd32768));
		repeat (3) send_item(make_item(ACT_START, 7'd5, 16'd0, 18'd0));
		send_item(make_item(ACT_END, 7'd5, 16'd0, 18'd0));
		// zero and full strength
		send_item(make_item(ACT_TRIGGER, 7'd9, 16'd10, 18'd0));
		send_item(make_item(ACT_TRIGGER, 7'd9, 16'd10, 18'h3FFFF));
		// retrigger of an over-limit note: off at the earlier of limit and position
		send_item(make_item(ACT_TRIGGER, 7'd20, 16'd300, 18'd40000));
		send_item(make_item(ACT_START, 7'd20, 16'd0, 18'd0));
		send_item(make_item(ACT_TRIGGER, 7'd20, 16'd50, 18'd1000));
		send_item(make_item(ACT_START, 7'd20, 16'd0, 18'd0));
		send_item(make_item(ACT_TRIGGER, 7'd20, 16'd450, 18'd70000));
		// spare action code with every field bit set
		send_item(make_item(ACT_SPARE, 7'h7F, 16'hFFFF, 18'h3FFFF));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: program_regs(24'd512, 24'd1000, 24'd0, 24'(FULL_Q16), 24'(FULL_Q16));
				1: program_regs(24'd1, 24'd1, 24'(FULL_Q16), 24'(FULL_Q16), 24'(FULL_Q16));
				2: program_regs(24'd8192, 24'hFFFFFF, 24'd0, 24'd0, 24'd0);
				3: program_regs(24'd0, 24'd3, 24'd20000, 24'd10000, 24'h1FFFF);
				4: program_regs(24'h3FFF, 24'd5000, 24'h1FFFF, 24'h1FFFF, 24'd30000);
				5: program_regs(24'd64, 24'd100, 24'd10000, 24'd50000, 24'd40000);
				6: program_regs(24'd300, 24'd700, 24'(FULL_Q16), 24'd0, 24'(FULL_Q16));
				default: program_regs(24'($urandom_range(1, 1024)), 24'($urandom_range(3000)),
					24'($urandom_range(24'h1FFFF)), 24'($urandom_range(24'h1FFFF)),
					24'($urandom_range(24'h1FFFF)));
			endcase
			if (p < 3) begin
				send_idle = 18;
				recv_idle = 57;
			end else if (p < 6) begin
				send_idle = 57;
				recv_idle = 18;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			refresh_pool();
			done = 0;
			while (done < RANDOM_ITEMS / PHASES) begin
				if ($urandom_range(99) < 10) begin
					refresh_pool();
				end
				if ($urandom_range(99) < 80) begin
					// one buffer: age the pool, fire a few notes, then check the limits
					foreach (pool[i]) begin
						send_item(make_item(ACT_START, pool[i], 16'($urandom), 18'($urandom)));
						done++;
					end
					repeat ($urandom_range(4)) begin
						case ($urandom_range(3))
							0: pos = 16'($urandom);
							1: pos = 16'($urandom_range(frame_now - 1));
							2: pos = 16'(frame_now - 1);
							default: pos = 16'($urandom_range(3));
						endcase
						case ($urandom_range(3))
							0: strength = 18'($urandom_range(TRIGGER_MIN + 1));
							1: strength = 18'($urandom_range(FULL_Q16 - 200, FULL_Q16 + 200));
							2: strength = 18'($urandom);
							default: strength = 18'($urandom_range(FULL_Q16));
						endcase
						send_item(make_item(ACT_TRIGGER, pool[$urandom_range(3)], pos, strength));
						done++;
					end
					foreach (pool[i]) begin
						if ($urandom_range(99) < 70) begin
							send_item(make_item(ACT_END, pool[i], 16'($urandom), 18'($urandom)));
							done++;
						end
					end
				end else begin
					noise = make_item(2'($urandom_range(3)), 7'($urandom), 16'($urandom),
						18'($urandom));
					send_item(noise);
					if (noise.action != ACT_SPARE) begin
						done++;
					end
				end
			end
		end

		drain();
		if (errors == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ note_length_limiter.f @@
hdl/nll_pkg.sv
hdl/nll_ram.sv
hdl/nll_fifo.sv
hdl/nll_front.sv
hdl/nll_back.sv
hdl/note_length_limiter.sv
test/nll_checker.sv
test/tb_top.sv
